// ===== sv/drre_pkg.sv =====
// shared types and constants of the dithered rectangle draw engine
package drre_pkg;

  localparam int unsigned StoreDepth = 16384;
  localparam int unsigned StoreAw    = 14;

  localparam logic [1:0] OP_LINE    = 2'd0;
  localparam logic [1:0] OP_OUTLINE = 2'd1;
  localparam logic [1:0] OP_FILL    = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  rect_left;
    logic [7:0]  rect_top;
    logic [9:0]  rect_width;
    logic [7:0]  rect_height;
    logic [3:0]  color;
    logic [13:0] read_address;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
  } rsp_t;

  typedef enum logic [1:0] {
    PK_BLOCK = 2'd0,
    PK_SPAN  = 2'd1,
    PK_READ  = 2'd2
  } prim_kind_e;

  // one drawing primitive handed from the sequencer to the byte walker
  typedef struct packed {
    prim_kind_e         kind;
    logic [15:0]        col_a;
    logic [15:0]        col_b;
    logic [15:0]        line;
    logic [7:0]         mask;
    logic [7:0]         pat;
    logic [StoreAw-1:0] raddr;
  } prim_t;

  typedef struct packed {
    logic prim_ready;
    logic rd_valid;
    logic clearing;
  } wk_stat_t;

endpackage

// ===== sv/drre_ram.sv =====
// generic single-port synchronous ram with registered read
module drre_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/drre_walk.sv =====
// byte walker: clearing pass, masked read-modify-write, spans and reads on the frame store
module drre_walk #(
  parameter int unsigned LINE_BYTES       = 80,
  parameter int unsigned ODD_PLANE_OFFSET = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              prim_valid_i,
  input  drre_pkg::prim_t   prim_i,
  output drre_pkg::wk_stat_t stat_o,
  output logic [7:0]        rdata_o
);

  localparam int unsigned AddrW = 17 + $clog2(LINE_BYTES);
  localparam int unsigned Aw    = drre_pkg::StoreAw;

  typedef enum logic [5:0] {
    W_CLEAR = 6'b000001,
    W_IDLE  = 6'b000010,
    W_BASE  = 6'b000100,
    W_ACC   = 6'b001000,
    W_WR    = 6'b010000,
    W_RD    = 6'b100000
  } wstate_e;

  wstate_e state_q, state_d;
  logic [Aw-1:0] clr_q, clr_d;
  drre_pkg::prim_kind_e kind_q, kind_d;
  logic [15:0] line_q, line_d;
  logic [7:0] mask_q, mask_d, pat_q, pat_d;
  logic [13:0] b_q, b_d;
  logic [12:0] end_q, end_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [Aw-1:0] addr_q, addr_d;

  logic ram_en, ram_we;
  logic [Aw-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;
  logic [AddrW-1:0] acc_addr;
  logic in_store, span_done;

  assign acc_addr  = base_q + AddrW'(b_q);
  assign in_store  = acc_addr < AddrW'(drre_pkg::StoreDepth);
  assign span_done = b_q >= {1'b0, end_q};

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    kind_d    = kind_q;
    line_d    = line_q;
    mask_d    = mask_q;
    pat_d     = pat_q;
    b_d       = b_q;
    end_d     = end_q;
    base_d    = base_q;
    addr_d    = addr_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = '0;
    unique case (state_q)
      W_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + Aw'(1);
        if (&clr_q) begin
          state_d = W_IDLE;
        end
      end
      W_IDLE: begin
        if (prim_valid_i) begin
          kind_d = prim_i.kind;
          line_d = prim_i.line;
          mask_d = prim_i.mask;
          pat_d  = prim_i.pat;
          end_d  = prim_i.col_b[15:3];
          if (prim_i.kind == drre_pkg::PK_SPAN) begin
            // span starts at the first whole byte
            b_d = {1'b0, prim_i.col_a[15:3]} + 14'(|prim_i.col_a[2:0]);
          end else begin
            b_d = {1'b0, prim_i.col_a[15:3]};
          end
          if (prim_i.kind == drre_pkg::PK_READ) begin
            ram_en   = 1'b1;
            ram_addr = prim_i.raddr;
            state_d  = W_RD;
          end else begin
            state_d = W_BASE;
          end
        end
      end
      W_BASE: begin
        base_d  = (line_q[0] ? AddrW'(ODD_PLANE_OFFSET) : '0)
                + AddrW'(line_q[15:1]) * AddrW'(LINE_BYTES);
        state_d = W_ACC;
      end
      W_ACC: begin
        if (kind_q == drre_pkg::PK_SPAN) begin
          if (span_done) begin
            state_d = W_IDLE;
          end else begin
            if (in_store) begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = acc_addr[Aw-1:0];
              ram_wdata = pat_q;
            end
            b_d = b_q + 14'd1;
          end
        end else if (in_store) begin
          ram_en   = 1'b1;
          ram_addr = acc_addr[Aw-1:0];
          addr_d   = acc_addr[Aw-1:0];
          state_d  = W_WR;
        end else begin
          state_d = W_IDLE;
        end
      end
      W_WR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = addr_q;
        ram_wdata = (ram_rdata & ~mask_q) | (pat_q & mask_q);
        state_d   = W_IDLE;
      end
      W_RD: begin
        state_d = W_IDLE;
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    line_q <= line_d;
    mask_q <= mask_d;
    pat_q  <= pat_d;
    b_q    <= b_d;
    end_q  <= end_d;
    base_q <= base_d;
    addr_q <= addr_d;
  end

  drre_ram #(
    .Width(8),
    .Depth(drre_pkg::StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign stat_o.prim_ready = (state_q == W_IDLE);
  assign stat_o.rd_valid   = (state_q == W_RD);
  assign stat_o.clearing   = (state_q == W_CLEAR);
  assign rdata_o           = ram_rdata;

  a_wr_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == W_WR |-> $past(state_q == W_ACC))
    else $error("merge write without a preceding read");
  a_rd_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == W_RD |-> $past(state_q == W_IDLE && prim_valid_i))
    else $error("read data stage without a read request");
  a_clear_only_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == W_CLEAR && !$past(state_q == W_CLEAR) |-> clr_q == '0)
    else $error("clearing pass entered mid-way");

endmodule

// ===== sv/dithered_rect_draw_engine.sv =====
// top level: command decode and primitive sequencer of the dithered rectangle draw engine
// drawing: each edge byte is a masked read-modify-write and each row span writes its
//   interior bytes one at a time, with a step per pass change and for decode and
//   response, so cost grows with area
// throughput: one command at a time; the single frame store port sets the pace
// reset: the frame store is swept to zero, one byte a cycle, all 16384 bytes,
//   and no command beat is taken until the sweep is done
module dithered_rect_draw_engine #(
  parameter int unsigned LINE_BYTES       = 80,
  parameter int unsigned ODD_PLANE_OFFSET = 8192
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  drre_pkg::cmd_t in_beat_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output drre_pkg::rsp_t out_beat_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIX    = 6'b000010,
    S_LOOP   = 6'b000100,
    S_READ   = 6'b001000,
    S_RDWAIT = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  // colour index to brush number
  function automatic logic [2:0] brush_of(input logic [3:0] c);
    logic [2:0] b;
    unique case (c)
      4'd0, 4'd1, 4'd2, 4'd4:                 b = 3'd0;
      4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12:   b = 3'd1;
      4'd8, 4'd11, 4'd13, 4'd14:              b = 3'd2;
      4'd7:                                   b = 3'd3;
      default:                                b = 3'd4;
    endcase
    return b;
  endfunction

  // brush pattern for even or odd pixel rows
  function automatic logic [7:0] brush_row(input logic [2:0] b, input logic odd);
    logic [7:0] p;
    unique case (b)
      3'd1:    p = odd ? 8'h22 : 8'h88;
      3'd2:    p = odd ? 8'h55 : 8'hAA;
      3'd3:    p = odd ? 8'hDD : 8'h77;
      3'd4:    p = 8'hFF;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] left_mask(input logic [2:0] r);
    return 8'hFF >> r;
  endfunction

  // inclusive right edge: keeps the end pixel
  function automatic logic [7:0] right_mask_incl(input logic [2:0] r);
    return 8'hFF << (3'd7 - r);
  endfunction

  // exclusive right edge used by the fill
  function automatic logic [7:0] right_mask_excl(input logic [2:0] r);
    return ~(8'hFF >> r);
  endfunction

  function automatic logic [7:0] bit_of(input logic [2:0] r);
    return 8'h80 >> r;
  endfunction

  state_e state_q, state_d;
  logic [15:0] col_a_q, col_a_d, col_b_q, col_b_d;
  logic [15:0] row_a_q, row_a_d, row_b_q, row_b_d;
  logic [7:0] fm_a_q, fm_a_d, fm_b_q, fm_b_d, lm_a_q, lm_a_d, lm_b_q, lm_b_d;
  logic [2:0] brush_q, brush_d;
  logic [7:0] y_q, y_d;
  logic [8:0] bottom_q, bottom_d;
  logic outline_q, outline_d, two_q, two_d, has_l2_q, has_l2_d, loop2_q, loop2_d;
  logic pass_q, pass_d, item_q, item_d;
  logic [9:0] line_q, line_d;
  logic [2:0] fix_k_q, fix_k_d;
  logic status_q, status_d;
  logic [13:0] raddr_q, raddr_d;
  logic [7:0] rd_q, rd_d;
  logic out_valid_q, out_valid_d;
  drre_pkg::rsp_t out_q, out_d;

  drre_pkg::prim_t prim;
  logic prim_valid, prim_acc;
  drre_pkg::wk_stat_t stat;
  logic [7:0] walk_rdata;

  // fixed primitive table decode
  logic f_span, f_selb, f_rowb;
  logic [2:0] fix_last;

  // command fields
  logic [15:0] right16, left16;
  logic [8:0] bottom9;

  assign in_ready_o = (state_q == S_IDLE) && !stat.clearing;
  assign prim_acc   = prim_valid && stat.prim_ready;
  assign right16    = 16'(in_beat_i.rect_left) + 16'(in_beat_i.rect_width);
  assign left16     = 16'(in_beat_i.rect_left) - 16'd1;
  assign bottom9    = 9'(in_beat_i.rect_top) + 9'(in_beat_i.rect_height);
  assign fix_last   = outline_q ? 3'd5 : 3'd2;

  always_comb begin
    f_span = 1'b0;
    f_selb = 1'b0;
    f_rowb = 1'b0;
    if (outline_q) begin
      // top corners and span, then bottom corners and span
      unique case (fix_k_q)
        3'd1:    f_selb = 1'b1;
        3'd2:    f_span = 1'b1;
        3'd3:    f_rowb = 1'b1;
        3'd4:    begin f_selb = 1'b1; f_rowb = 1'b1; end
        3'd5:    begin f_span = 1'b1; f_rowb = 1'b1; end
        default: f_span = 1'b0;
      endcase
    end else begin
      // horizontal line: left edge, span, right edge
      unique case (fix_k_q)
        3'd1:    f_span = 1'b1;
        3'd2:    f_selb = 1'b1;
        default: f_span = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    col_a_d     = col_a_q;
    col_b_d     = col_b_q;
    row_a_d     = row_a_q;
    row_b_d     = row_b_q;
    fm_a_d      = fm_a_q;
    fm_b_d      = fm_b_q;
    lm_a_d      = lm_a_q;
    lm_b_d      = lm_b_q;
    brush_d     = brush_q;
    y_d         = y_q;
    bottom_d    = bottom_q;
    outline_d   = outline_q;
    two_d       = two_q;
    has_l2_d    = has_l2_q;
    loop2_d     = loop2_q;
    pass_d      = pass_q;
    item_d      = item_q;
    line_d      = line_q;
    fix_k_d     = fix_k_q;
    status_d    = status_q;
    raddr_d     = raddr_q;
    rd_d        = rd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    prim_valid  = 1'b0;
    prim        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          y_d       = in_beat_i.rect_top;
          bottom_d  = bottom9;
          brush_d   = brush_of(in_beat_i.color);
          status_d  = 1'b0;
          rd_d      = '0;
          col_b_d   = right16;
          loop2_d   = 1'b0;
          pass_d    = 1'b0;
          item_d    = 1'b0;
          line_d    = 10'(in_beat_i.rect_top);
          fix_k_d   = '0;
          outline_d = 1'b0;
          two_d     = 1'b0;
          has_l2_d  = 1'b0;
          unique case (in_beat_i.op)
            drre_pkg::OP_LINE: begin
              col_a_d = 16'(in_beat_i.rect_left);
              row_a_d = 16'(in_beat_i.rect_top);
              fm_a_d  = left_mask(in_beat_i.rect_left[2:0]);
              fm_b_d  = right_mask_incl(right16[2:0]);
              lm_a_d  = bit_of(in_beat_i.rect_left[2:0]);
              if (in_beat_i.rect_height == 8'd1) begin
                state_d = S_FIX;
              end else if (in_beat_i.rect_width == 10'd1) begin
                state_d = S_LOOP;
              end else begin
                status_d = 1'b1;
                state_d  = S_RESP;
              end
            end
            drre_pkg::OP_OUTLINE: begin
              // frame one pixel outside; a zero top wraps the top row far out of the store
              col_a_d   = left16;
              row_a_d   = 16'(in_beat_i.rect_top) - 16'd1;
              row_b_d   = 16'(bottom9);
              fm_a_d    = left_mask(left16[2:0]);
              fm_b_d    = right_mask_incl(right16[2:0]);
              lm_a_d    = bit_of(left16[2:0]);
              lm_b_d    = bit_of(right16[2:0]);
              two_d     = 1'b1;
              outline_d = 1'b1;
              state_d   = S_FIX;
            end
            drre_pkg::OP_FILL: begin
              // edge bytes of every row first, then interior spans
              col_a_d  = 16'(in_beat_i.rect_left);
              lm_a_d   = left_mask(in_beat_i.rect_left[2:0]);
              lm_b_d   = right_mask_excl(right16[2:0]);
              two_d    = 1'b1;
              has_l2_d = 1'b1;
              state_d  = S_LOOP;
            end
            default: begin
              raddr_d = in_beat_i.read_address;
              state_d = S_READ;
            end
          endcase
        end
      end
      S_FIX: begin
        prim_valid = 1'b1;
        prim.kind  = f_span ? drre_pkg::PK_SPAN : drre_pkg::PK_BLOCK;
        prim.col_a = (f_selb && !f_span) ? col_b_q : col_a_q;
        prim.col_b = col_b_q;
        prim.line  = f_rowb ? row_b_q : row_a_q;
        prim.mask  = f_selb ? fm_b_q : fm_a_q;
        prim.pat   = brush_row(brush_q, prim.line[0]);
        if (prim_acc) begin
          if (fix_k_q == fix_last) begin
            state_d = outline_q ? S_LOOP : S_RESP;
          end else begin
            fix_k_d = fix_k_q + 3'd1;
          end
        end
      end
      S_LOOP: begin
        // every other row from y, then from y+1, to bottom-1; a fill runs both twice
        if (line_q >= {1'b0, bottom_q}) begin
          if (!pass_q) begin
            pass_d = 1'b1;
            line_d = 10'(y_q) + 10'd1;
          end else if (!loop2_q && has_l2_q) begin
            loop2_d = 1'b1;
            pass_d  = 1'b0;
            line_d  = 10'(y_q);
          end else begin
            state_d = S_RESP;
          end
        end else begin
          prim_valid = 1'b1;
          prim.kind  = loop2_q ? drre_pkg::PK_SPAN : drre_pkg::PK_BLOCK;
          prim.col_a = (item_q && !loop2_q) ? col_b_q : col_a_q;
          prim.col_b = col_b_q;
          prim.line  = 16'(line_q);
          prim.mask  = item_q ? lm_b_q : lm_a_q;
          prim.pat   = brush_row(brush_q, line_q[0]);
          if (prim_acc) begin
            if (item_q || !two_q || loop2_q) begin
              item_d = 1'b0;
              line_d = line_q + 10'd2;
            end else begin
              item_d = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        prim_valid = 1'b1;
        prim.kind  = drre_pkg::PK_READ;
        prim.raddr = raddr_q;
        if (prim_acc) begin
          state_d = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        if (stat.rd_valid) begin
          rd_d    = walk_rdata;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        // result register frees the sequencer while the beat waits
        if (!out_valid_q || out_ready_i) begin
          out_d.status    = status_q;
          out_d.read_data = rd_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_a_q   <= col_a_d;
    col_b_q   <= col_b_d;
    row_a_q   <= row_a_d;
    row_b_q   <= row_b_d;
    fm_a_q    <= fm_a_d;
    fm_b_q    <= fm_b_d;
    lm_a_q    <= lm_a_d;
    lm_b_q    <= lm_b_d;
    brush_q   <= brush_d;
    y_q       <= y_d;
    bottom_q  <= bottom_d;
    outline_q <= outline_d;
    two_q     <= two_d;
    has_l2_q  <= has_l2_d;
    loop2_q   <= loop2_d;
    pass_q    <= pass_d;
    item_q    <= item_d;
    line_q    <= line_d;
    fix_k_q   <= fix_k_d;
    status_q  <= status_d;
    raddr_q   <= raddr_d;
    rd_q      <= rd_d;
    out_q     <= out_d;
  end

  drre_walk #(
    .LINE_BYTES      (LINE_BYTES),
    .ODD_PLANE_OFFSET(ODD_PLANE_OFFSET)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prim_valid_i(prim_valid),
    .prim_i      (prim),
    .stat_o      (stat),
    .rdata_o     (walk_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_no_prim_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !prim_acc)
    else $error("primitive taken during clearing pass");
  a_rd_only_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.rd_valid |-> state_q == S_RDWAIT)
    else $error("read data returned with no read outstanding");
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result beat raised outside the response state");
  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RDWAIT |-> !status_q)
    else $error("read op carries an invalid shape status");

endmodule
